// ===== hw/rtl/rmj_pkg.sv =====
`timescale 1ns / 1ps
package rmj_pkg;

    localparam int WORD_W     = 32;
    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = 32;
    // Quotient bits resolved by one divider lane; anything wider has overflowed.
    localparam int QUO_BITS   = 33;

    localparam logic [WORD_W-1:0] MIN_RANGE_SQ_RESET = 32'd6554;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage

// ===== hw/rtl/rmj_in_if.sv =====
`timescale 1ns / 1ps
interface rmj_in_if;
    import rmj_pkg::*;

    logic  valid;
    logic  ready;
    word_t pos_x;
    word_t pos_y;
    word_t vel_x;
    word_t vel_y;

    modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                    output ready);
endinterface

// ===== hw/rtl/rmj_out_if.sv =====
`timescale 1ns / 1ps
interface rmj_out_if;
    import rmj_pkg::*;

    logic  valid;
    logic  ready;
    word_t range_dpx;
    word_t range_dpy;
    word_t bearing_dpx;
    word_t bearing_dpy;
    word_t rate_dpx;
    word_t rate_dpy;
    logic  near_origin;
    logic  saturated;

    modport source (output valid, output range_dpx, output range_dpy, output bearing_dpx,
                    output bearing_dpy, output rate_dpx, output rate_dpy,
                    output near_origin, output saturated, input ready);
    modport sink   (input valid, input range_dpx, input range_dpy, input bearing_dpx,
                    input bearing_dpy, input rate_dpx, input rate_dpy,
                    input near_origin, input saturated, output ready);
endinterface

// ===== hw/rtl/rmj_sqrt_cell.sv =====
`timescale 1ns / 1ps
module rmj_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rmj_pkg::SQRT_W-1:0] v_in,
    input  logic [rmj_pkg::SQRT_W-1:0] res_in,
    output logic [rmj_pkg::SQRT_W-1:0] v_out,
    output logic [rmj_pkg::SQRT_W-1:0] res_out
);
    import rmj_pkg::*;

    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * STEP);

    logic [SQRT_W:0]   trial;
    logic              take;
    logic [SQRT_W-1:0] v_next;
    logic [SQRT_W-1:0] res_next;

    always_comb
    begin
        trial = {1'b0, res_in} + {1'b0, BIT};
        take  = {1'b0, v_in} >= trial;
        if (take)
        begin
            v_next   = v_in - trial[SQRT_W-1:0];
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out   <= v_next;
            res_out <= res_next;
        end
    end
endmodule

// ===== hw/rtl/rmj_div_cell.sv =====
`timescale 1ns / 1ps
module rmj_div_cell #(
    parameter int DEN_W = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [DEN_W-1:0]              rem_in,
    input  logic [DEN_W-1:0]              den_in,
    input  logic [rmj_pkg::QUO_BITS-1:0]  z_in,
    input  logic                          ovf_in,
    output logic [DEN_W-1:0]              rem_out,
    output logic [DEN_W-1:0]              den_out,
    output logic [rmj_pkg::QUO_BITS-1:0]  z_out,
    output logic                          ovf_out
);
    import rmj_pkg::*;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;
    logic [DEN_W-1:0]  rem_next;

    // z holds the unused numerator bits at the top and the quotient bits found so far below.
    always_comb
    begin
        trial    = {rem_in, z_in[QUO_BITS-1]};
        diff     = trial - {1'b0, den_in};
        take     = trial >= {1'b0, den_in};
        rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            den_out <= den_in;
            z_out   <= {z_in[QUO_BITS-2:0], take};
            ovf_out <= ovf_in;
        end
    end
endmodule

// ===== hw/rtl/rmj_div_lane.sv =====
`timescale 1ns / 1ps
module rmj_div_lane #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    output logic [rmj_pkg::QUO_BITS-1:0]  quo,
    output logic                          ovf
);
    import rmj_pkg::*;

    localparam int HI_W = NUM_W - QUO_BITS;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] hi_x;
    logic [CMP_W-1:0] den_x;
    logic             ovf_pre;

    logic [DEN_W-1:0]    rem_w [0:QUO_BITS];
    logic [DEN_W-1:0]    den_w [0:QUO_BITS];
    logic [QUO_BITS-1:0] z_w   [0:QUO_BITS];
    logic                ovf_w [0:QUO_BITS];

    // The quotient fits in QUO_BITS bits exactly when the numerator's upper part is below den.
    always_comb
    begin
        hi_x    = CMP_W'(num[NUM_W-1:QUO_BITS]);
        den_x   = CMP_W'(den);
        ovf_pre = hi_x >= den_x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_w[0] <= ovf_pre ? '0 : DEN_W'(hi_x);
            den_w[0] <= den;
            z_w[0]   <= num[QUO_BITS-1:0];
            ovf_w[0] <= ovf_pre;
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        rmj_div_cell #(.DEN_W(DEN_W)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[i]),
            .den_in  (den_w[i]),
            .z_in    (z_w[i]),
            .ovf_in  (ovf_w[i]),
            .rem_out (rem_w[i+1]),
            .den_out (den_w[i+1]),
            .z_out   (z_w[i+1]),
            .ovf_out (ovf_w[i+1])
        );
    end

    assign quo = z_w[QUO_BITS];
    assign ovf = ovf_w[QUO_BITS];
endmodule

// ===== hw/rtl/radar_measurement_jacobian.sv =====
`timescale 1ns / 1ps
// Radar measurement Jacobian for a constant-velocity state in signed fixed point.
// The state_vec channel takes one item of pos_x, pos_y, vel_x and vel_y; the jac
// channel returns one item with the six distinct Jacobian entries and two flags.
// Both channels use valid/ready; an item moves on an edge where both are high.
// cfg_we with cfg_wdata writes the near-origin threshold on range squared; write
// it only while no item is in flight.
// The path has 71 register stages: one multiply stage, one sum and range check
// stage, 32 square-root cells, two multiply stages, one divider input stage, 33
// divider cells and the output register. Throughput is one item per cycle while
// the chain is not held, set by the chain of cells, each handing its item to
// the next every cycle.
// When jac stalls, one extra item lands in a skid register and the whole chain
// then holds, dropping state_vec.ready until the skid register drains.
// Reset empties the chain and both output registers and restores the threshold
// to its reset value.
module radar_measurement_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rmj_in_if.sink                       state_vec,
    rmj_out_if.source                    jac,
    input  logic                         cfg_we,
    input  logic [rmj_pkg::WORD_W-1:0]   cfg_wdata
);
    import rmj_pkg::*;

    localparam int N0_W = WORD_W + FRAC_BITS;
    localparam int N2_W = WORD_W + 2 * FRAC_BITS;
    localparam int N4_W = 3 * WORD_W + FRAC_BITS;
    localparam int SIDE_LEN = SQRT_STEPS + 3 + QUO_BITS + 1;

    typedef struct packed {
        logic       near;
        logic [5:0] neg;
    } side_t;

    typedef struct packed {
        logic [63:0] r2;
        logic [31:0] apx;
        logic [31:0] apy;
        logic [63:0] cmag;
    } pay_t;

    typedef struct packed {
        word_t range_dpx;
        word_t range_dpy;
        word_t bearing_dpx;
        word_t bearing_dpy;
        word_t rate_dpx;
        word_t rate_dpy;
        logic  near_origin;
        logic  saturated;
    } res_t;

    logic                en;
    logic [WORD_W-1:0]   min_reg;

    // First stage: products straight from the accepted item.
    logic                s1_valid_reg;
    logic signed [63:0]  pxx_reg, pyy_reg, a_reg, b_reg;
    logic [31:0]         apx_reg, apy_reg;
    logic                sx_reg, sy_reg, py_pos_reg;

    // Second stage combinational values.
    logic [63:0]         r2_c;
    logic signed [64:0]  diff_c;
    logic                cneg_c;
    logic [63:0]         cmag_c;
    logic                near_c;

    logic                vld_reg  [0:SIDE_LEN-1];
    side_t               side_reg [0:SIDE_LEN-1];
    pay_t                pay_reg  [0:SQRT_STEPS];

    logic [SQRT_W-1:0]   sq_v   [0:SQRT_STEPS];
    logic [SQRT_W-1:0]   sq_res [0:SQRT_STEPS];

    logic [31:0]         r_c;
    logic [63:0]         p_rlo_reg, p_rhi_reg, p_ylo_reg, p_yhi_reg, p_xlo_reg, p_xhi_reg;
    logic [31:0]         m1_r_reg, m1_apx_reg, m1_apy_reg;
    logic [63:0]         m1_r2_reg;

    logic [31:0]         m2_r_reg, m2_apx_reg, m2_apy_reg;
    logic [63:0]         m2_r2_reg;
    logic [95:0]         m2_r3_reg, m2_yc_reg, m2_xc_reg;

    logic [QUO_BITS-1:0] quo [0:5];
    logic                ovf [0:5];

    logic                tail_valid;
    side_t               tail_side;
    res_t                fin;
    logic [32:0]         fw  [0:5];

    logic                out_valid_reg;
    res_t                out_reg;
    logic                skid_valid_reg;
    res_t                skid_reg;

    function automatic logic [32:0] finish_word(input logic [QUO_BITS-1:0] q,
                                                input logic ovf_in, input logic neg);
        logic [QUO_BITS-1:0] lim;
        logic                sat;
        logic [31:0]         w;
        lim = neg ? QUO_BITS'(33'h080000000) : QUO_BITS'(33'h07FFFFFFF);
        sat = ovf_in || (q > lim);
        if (sat)
            w = neg ? 32'h80000000 : 32'h7FFFFFFF;
        else
            w = neg ? (32'd0 - q[31:0]) : q[31:0];
        return {sat, w};
    endfunction

    assign en              = !skid_valid_reg;
    assign state_vec.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= MIN_RANGE_SQ_RESET;
        else if (cfg_we)
            min_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg    <= state_vec.pos_x * state_vec.pos_x;
            pyy_reg    <= state_vec.pos_y * state_vec.pos_y;
            a_reg      <= state_vec.vel_x * state_vec.pos_y;
            b_reg      <= state_vec.vel_y * state_vec.pos_x;
            apx_reg    <= state_vec.pos_x[31] ? (32'd0 - state_vec.pos_x) : state_vec.pos_x;
            apy_reg    <= state_vec.pos_y[31] ? (32'd0 - state_vec.pos_y) : state_vec.pos_y;
            sx_reg     <= state_vec.pos_x[31];
            sy_reg     <= state_vec.pos_y[31];
            py_pos_reg <= !state_vec.pos_y[31] && (state_vec.pos_y != '0);
        end
    end

    always_comb
    begin
        r2_c   = pxx_reg + pyy_reg;
        diff_c = {a_reg[63], a_reg} - {b_reg[63], b_reg};
        cneg_c = diff_c[64];
        cmag_c = cneg_c ? 64'(65'd0 - diff_c) : diff_c[63:0];
        near_c = (r2_c == '0) || ((r2_c >> FRAC_BITS) < {32'd0, min_reg});
    end

    // Valid bits of every stage; index 0 is the sum stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < SIDE_LEN; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= state_vec.valid;
            vld_reg[0]   <= s1_valid_reg;
            for (int i = 1; i < SIDE_LEN; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].near <= near_c;
            side_reg[0].neg  <= {sx_reg != !cneg_c, sy_reg != cneg_c,
                                 sx_reg, py_pos_reg, sy_reg, sx_reg};
            for (int i = 1; i < SIDE_LEN; i++)
                side_reg[i] <= side_reg[i-1];

            pay_reg[0].r2   <= r2_c;
            pay_reg[0].apx  <= apx_reg;
            pay_reg[0].apy  <= apy_reg;
            pay_reg[0].cmag <= cmag_c;
            for (int i = 1; i <= SQRT_STEPS; i++)
                pay_reg[i] <= pay_reg[i-1];
        end
    end

    assign sq_v[0]   = pay_reg[0].r2;
    assign sq_res[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        rmj_sqrt_cell #(.STEP(k)) u_cell (
            .clk     (clk),
            .en      (en),
            .v_in    (sq_v[k]),
            .res_in  (sq_res[k]),
            .v_out   (sq_v[k+1]),
            .res_out (sq_res[k+1])
        );
    end

    assign r_c = sq_res[SQRT_STEPS][31:0];

    // Products wider than 32 by 32 bits are split into halves and summed a stage later.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rlo_reg  <= 64'(pay_reg[SQRT_STEPS].r2[31:0]) * 64'(r_c);
            p_rhi_reg  <= 64'(pay_reg[SQRT_STEPS].r2[63:32]) * 64'(r_c);
            p_ylo_reg  <= 64'(pay_reg[SQRT_STEPS].cmag[31:0]) * 64'(pay_reg[SQRT_STEPS].apy);
            p_yhi_reg  <= 64'(pay_reg[SQRT_STEPS].cmag[63:32]) * 64'(pay_reg[SQRT_STEPS].apy);
            p_xlo_reg  <= 64'(pay_reg[SQRT_STEPS].cmag[31:0]) * 64'(pay_reg[SQRT_STEPS].apx);
            p_xhi_reg  <= 64'(pay_reg[SQRT_STEPS].cmag[63:32]) * 64'(pay_reg[SQRT_STEPS].apx);
            m1_r_reg   <= r_c;
            m1_r2_reg  <= pay_reg[SQRT_STEPS].r2;
            m1_apx_reg <= pay_reg[SQRT_STEPS].apx;
            m1_apy_reg <= pay_reg[SQRT_STEPS].apy;

            m2_r3_reg  <= {32'd0, p_rlo_reg} + {p_rhi_reg, 32'd0};
            m2_yc_reg  <= {32'd0, p_ylo_reg} + {p_yhi_reg, 32'd0};
            m2_xc_reg  <= {32'd0, p_xlo_reg} + {p_xhi_reg, 32'd0};
            m2_r_reg   <= m1_r_reg;
            m2_r2_reg  <= m1_r2_reg;
            m2_apx_reg <= m1_apx_reg;
            m2_apy_reg <= m1_apy_reg;
        end
    end

    rmj_div_lane #(.NUM_W(N0_W), .DEN_W(32)) u_div0 (
        .clk (clk), .en (en), .num ({m2_apx_reg, {FRAC_BITS{1'b0}}}), .den (m2_r_reg),
        .quo (quo[0]), .ovf (ovf[0]));
    rmj_div_lane #(.NUM_W(N0_W), .DEN_W(32)) u_div1 (
        .clk (clk), .en (en), .num ({m2_apy_reg, {FRAC_BITS{1'b0}}}), .den (m2_r_reg),
        .quo (quo[1]), .ovf (ovf[1]));
    rmj_div_lane #(.NUM_W(N2_W), .DEN_W(64)) u_div2 (
        .clk (clk), .en (en), .num ({m2_apy_reg, {(2 * FRAC_BITS){1'b0}}}), .den (m2_r2_reg),
        .quo (quo[2]), .ovf (ovf[2]));
    rmj_div_lane #(.NUM_W(N2_W), .DEN_W(64)) u_div3 (
        .clk (clk), .en (en), .num ({m2_apx_reg, {(2 * FRAC_BITS){1'b0}}}), .den (m2_r2_reg),
        .quo (quo[3]), .ovf (ovf[3]));
    rmj_div_lane #(.NUM_W(N4_W), .DEN_W(96)) u_div4 (
        .clk (clk), .en (en), .num ({m2_yc_reg, {FRAC_BITS{1'b0}}}), .den (m2_r3_reg),
        .quo (quo[4]), .ovf (ovf[4]));
    rmj_div_lane #(.NUM_W(N4_W), .DEN_W(96)) u_div5 (
        .clk (clk), .en (en), .num ({m2_xc_reg, {FRAC_BITS{1'b0}}}), .den (m2_r3_reg),
        .quo (quo[5]), .ovf (ovf[5]));

    assign tail_valid = vld_reg[SIDE_LEN-1];
    assign tail_side  = side_reg[SIDE_LEN-1];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            fw[k] = finish_word(quo[k], ovf[k], tail_side.neg[k]);
        if (tail_side.near)
        begin
            fin             = '0;
            fin.near_origin = 1'b1;
        end
        else
        begin
            fin.range_dpx   = fw[0][31:0];
            fin.range_dpy   = fw[1][31:0];
            fin.bearing_dpx = fw[2][31:0];
            fin.bearing_dpy = fw[3][31:0];
            fin.rate_dpx    = fw[4][31:0];
            fin.rate_dpy    = fw[5][31:0];
            fin.near_origin = 1'b0;
            fin.saturated   = fw[0][32] | fw[1][32] | fw[2][32] | fw[3][32]
                            | fw[4][32] | fw[5][32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (jac.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= tail_valid;
        end
        else if (tail_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (jac.ready || !out_valid_reg)
            out_reg <= skid_valid_reg ? skid_reg : fin;
        else if (en && tail_valid)
            skid_reg <= fin;
    end

    assign jac.valid       = out_valid_reg;
    assign jac.range_dpx   = out_reg.range_dpx;
    assign jac.range_dpy   = out_reg.range_dpy;
    assign jac.bearing_dpx = out_reg.bearing_dpx;
    assign jac.bearing_dpy = out_reg.bearing_dpy;
    assign jac.rate_dpx    = out_reg.rate_dpx;
    assign jac.rate_dpy    = out_reg.rate_dpy;
    assign jac.near_origin = out_reg.near_origin;
    assign jac.saturated   = out_reg.saturated;
endmodule
